// ===== design/convex_hull_gift_wrap_core_assert.svh =====
// Assertion macros for the convex hull core.
// Included by the top level; the macros expand to nothing when SYNTHESIS is defined.
`ifndef CONVEX_HULL_GIFT_WRAP_CORE_ASSERT_SVH
`define CONVEX_HULL_GIFT_WRAP_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define CHGW_ASSERT_IMP(lbl, c, r, a, b) \
  lbl: assert property (@(posedge c) disable iff (r) (a) |-> (b)) \
    else $error("same-cycle implication failed");
`define CHGW_ASSERT_NXT(lbl, c, r, a, b) \
  lbl: assert property (@(posedge c) disable iff (r) (a) |=> (b)) \
    else $error("next-cycle implication failed");
`else
`define CHGW_ASSERT_IMP(lbl, c, r, a, b)
`define CHGW_ASSERT_NXT(lbl, c, r, a, b)
`endif
`endif

// ===== design/chgw_pkg.sv =====
// Shared constants and types for the convex hull core.
// No dependencies; used by chgw_mac and the convex hull core.
package chgw_pkg;

  localparam int MAX_POINTS_DEF = 64;
  localparam int COORD_BITS_DEF = 16;

  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_ADD   = 2'd1;
  localparam logic [1:0] CMD_HULL  = 2'd2;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_EMPTY   = 2'd1;
  localparam logic [1:0] STATUS_DROPPED = 2'd2;

  // Control word for the shared multiply-accumulate unit.
  typedef struct packed {
    logic en;        // update an accumulator this cycle
    logic sel_dist;  // 1: squared-distance accumulator, 0: cross-product accumulator
    logic load;      // 1: load the product, 0: combine with the accumulator
  } mac_ctl_t;

endpackage

// ===== design/chgw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module chgw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/chgw_mac.sv =====
// Shared signed multiplier with a cross-product and a squared-distance accumulator.
// Depends on chgw_pkg for the control word.
module chgw_mac #(
  parameter int COORD_BITS = chgw_pkg::COORD_BITS_DEF
) (
  input  logic                          clk,
  input  chgw_pkg::mac_ctl_t            ctl,
  input  logic signed [COORD_BITS:0]    a,
  input  logic signed [COORD_BITS:0]    b,
  output logic signed [2*COORD_BITS+1:0] cross_acc,
  output logic signed [2*COORD_BITS+1:0] dist_acc
);

  logic signed [2*COORD_BITS+1:0] prod;

  assign prod = a * b;

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      if (ctl.sel_dist) begin
        dist_acc <= ctl.load ? prod : dist_acc + prod;
      end else begin
        cross_acc <= ctl.load ? prod : cross_acc - prod;
      end
    end
  end

endmodule

// ===== design/convex_hull_gift_wrap_core.sv =====
// Convex hull core: clear and add point never raise busy. With N stored points, compute
// finds the lowest point by reading and comparing each, then scans N points per vertex
// (read, load, cross product, squared distance, decide; the first candidate skips the
// cross product, a duplicate of the current vertex stops early) via one shared MAC
// and the store's read port, then emits. Each vertex appears for one cycle on valid;
// the receiver cannot stall. Synchronous reset empties the store and clears dropped.
`include "convex_hull_gift_wrap_core_assert.svh"
module convex_hull_gift_wrap_core #(
  parameter int MAX_POINTS = chgw_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = chgw_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [1:0]                   cmd,
  input  logic signed [COORD_BITS-1:0] x,
  input  logic signed [COORD_BITS-1:0] y,
  output logic                         busy,
  output logic                         valid,
  output logic signed [COORD_BITS-1:0] hull_x,
  output logic signed [COORD_BITS-1:0] hull_y,
  output logic                         last,
  output logic [1:0]                   status
);

  localparam int CB = COORD_BITS;
  localparam int IW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int PW = 2 * CB + 2;

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_LOW_RD  = 4'd1;
  localparam logic [3:0] ST_LOW_CMP = 4'd2;
  localparam logic [3:0] ST_RD      = 4'd3;
  localparam logic [3:0] ST_LD      = 4'd4;
  localparam logic [3:0] ST_C1      = 4'd5;
  localparam logic [3:0] ST_C2      = 4'd6;
  localparam logic [3:0] ST_D1      = 4'd7;
  localparam logic [3:0] ST_D2      = 4'd8;
  localparam logic [3:0] ST_DEC     = 4'd9;
  localparam logic [3:0] ST_EMIT    = 4'd10;

  logic [3:0]           state;
  logic [CW-1:0]        count;
  logic                 dropped;
  logic [IW-1:0]        idx;
  logic [CW-1:0]        k;
  logic                 found;
  logic signed [CB-1:0] best_x, best_y;
  logic signed [CB-1:0] cur_x, cur_y;
  logic signed [CB-1:0] nxt_x, nxt_y;
  logic signed [CB-1:0] cand_x, cand_y;
  logic signed [CB:0]   cdx, cdy;
  logic signed [CB:0]   ndx, ndy;
  logic signed [PW-1:0] dnxt;

  logic                 accept;
  logic                 ram_we;
  logic [2*CB-1:0]      rdata;
  logic signed [CB-1:0] rd_x, rd_y;
  logic                 idx_is_last;
  logic                 cand_same;
  logic                 take;
  logic                 fin;
  logic                 lower;

  chgw_pkg::mac_ctl_t   mac_ctl;
  logic signed [CB:0]   mac_a, mac_b;
  logic signed [PW-1:0] cross_acc, dist_acc;

  assign busy        = (state != ST_IDLE);
  assign accept      = start && !busy;
  assign ram_we      = accept && (cmd == chgw_pkg::CMD_ADD) && (count != CW'(MAX_POINTS));
  assign rd_x        = rdata[CB-1:0];
  assign rd_y        = rdata[2*CB-1:CB];
  assign idx_is_last = (CW'(idx) + CW'(1) == count);
  assign cand_same   = (cdx == '0) && (cdy == '0);
  assign lower       = (rd_y < best_y) || ((rd_y == best_y) && (rd_x < best_x));
  // Clockwise turn wins; on a collinear tie the farther candidate wins.
  assign take        = !found || cross_acc < 0 || (cross_acc == '0 && dist_acc > dnxt);
  assign fin         = !found || (nxt_x == best_x && nxt_y == best_y) ||
                       (k + CW'(1) >= count);

  chgw_ram #(
    .WIDTH (2 * CB),
    .DEPTH (MAX_POINTS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count[IW-1:0]),
    .wdata ({y, x}),
    .raddr (idx),
    .rdata (rdata)
  );

  always_comb begin
    mac_ctl = '0;
    mac_a   = ndx;
    mac_b   = cdy;
    unique case (state)
      ST_C1: begin
        mac_ctl = '{en: found && !cand_same, sel_dist: 1'b0, load: 1'b1};
      end
      ST_C2: begin
        mac_a   = ndy;
        mac_b   = cdx;
        mac_ctl = '{en: 1'b1, sel_dist: 1'b0, load: 1'b0};
      end
      ST_D1: begin
        mac_a   = cdx;
        mac_b   = cdx;
        mac_ctl = '{en: 1'b1, sel_dist: 1'b1, load: 1'b1};
      end
      ST_D2: begin
        mac_a   = cdy;
        mac_b   = cdy;
        mac_ctl = '{en: 1'b1, sel_dist: 1'b1, load: 1'b0};
      end
      default: begin
        mac_ctl = '0;
      end
    endcase
  end

  chgw_mac #(
    .COORD_BITS (CB)
  ) u_mac (
    .clk       (clk),
    .ctl       (mac_ctl),
    .a         (mac_a),
    .b         (mac_b),
    .cross_acc (cross_acc),
    .dist_acc  (dist_acc)
  );

  // A result goes out after each emit step, or right after a compute on an empty store.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= (state == ST_EMIT) ||
               (accept && (cmd == chgw_pkg::CMD_HULL) && (count == '0));
    end
  end

  // Sequencer and control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      count   <= '0;
      dropped <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            unique case (cmd)
              chgw_pkg::CMD_CLEAR: begin
                count   <= '0;
                dropped <= 1'b0;
              end
              chgw_pkg::CMD_ADD: begin
                if (count == CW'(MAX_POINTS)) begin
                  dropped <= 1'b1;
                end else begin
                  count <= count + CW'(1);
                end
              end
              chgw_pkg::CMD_HULL: begin
                if (count != '0) begin
                  state <= ST_LOW_RD;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_LOW_RD:  state <= ST_LOW_CMP;
        ST_LOW_CMP: state <= idx_is_last ? ST_RD : ST_LOW_RD;
        ST_RD:      state <= ST_LD;
        ST_LD:      state <= ST_C1;
        ST_C1: begin
          if (cand_same) begin
            state <= idx_is_last ? ST_EMIT : ST_RD;
          end else if (!found) begin
            state <= ST_D1;
          end else begin
            state <= ST_C2;
          end
        end
        ST_C2:  state <= ST_D1;
        ST_D1:  state <= ST_D2;
        ST_D2:  state <= ST_DEC;
        ST_DEC: state <= idx_is_last ? ST_EMIT : ST_RD;
        ST_EMIT: begin
          state <= fin ? ST_IDLE : ST_RD;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        idx    <= '0;
        hull_x <= '0;
        hull_y <= '0;
        last   <= 1'b1;
        status <= chgw_pkg::STATUS_EMPTY;
      end
      ST_LOW_CMP: begin
        if (idx == '0 || lower) begin
          best_x <= rd_x;
          best_y <= rd_y;
          cur_x  <= rd_x;
          cur_y  <= rd_y;
        end
        if (idx_is_last) begin
          idx   <= '0;
          found <= 1'b0;
          k     <= '0;
        end else begin
          idx <= idx + IW'(1);
        end
      end
      ST_LD: begin
        cand_x <= rd_x;
        cand_y <= rd_y;
        cdx    <= {rd_x[CB-1], rd_x} - {cur_x[CB-1], cur_x};
        cdy    <= {rd_y[CB-1], rd_y} - {cur_y[CB-1], cur_y};
      end
      ST_C1: begin
        if (cand_same && !idx_is_last) begin
          idx <= idx + IW'(1);
        end
      end
      ST_DEC: begin
        if (take) begin
          nxt_x <= cand_x;
          nxt_y <= cand_y;
          ndx   <= cdx;
          ndy   <= cdy;
          dnxt  <= dist_acc;
          found <= 1'b1;
        end
        if (!idx_is_last) begin
          idx <= idx + IW'(1);
        end
      end
      ST_EMIT: begin
        hull_x <= cur_x;
        hull_y <= cur_y;
        last   <= fin;
        status <= dropped ? chgw_pkg::STATUS_DROPPED : chgw_pkg::STATUS_OK;
        cur_x  <= nxt_x;
        cur_y  <= nxt_y;
        k      <= k + CW'(1);
        idx    <= '0;
        found  <= 1'b0;
      end
      default: begin
      end
    endcase
  end

  // A vertex that is not the final one leaves the walk running.
  `CHGW_ASSERT_IMP(a_mid_vertex_busy, clk, rst, valid && !last, busy)
  // A scan of at least one point separates two vertices of the same run.
  `CHGW_ASSERT_NXT(a_vertex_spacing, clk, rst, valid && !last, !valid)
  // The empty-store result is always a single, final one.
  `CHGW_ASSERT_IMP(a_empty_is_last, clk, rst, valid && status == chgw_pkg::STATUS_EMPTY, last)
  // A clear transaction leaves the store empty and the dropped flag clear in the next cycle.
  `CHGW_ASSERT_NXT(a_clear_empties, clk, rst, accept && cmd == chgw_pkg::CMD_CLEAR,
                   count == '0 && !dropped)

endmodule
